// File: hw/rtl/flm_pkg.sv
// ----------------------------------------------------------------------------
// flm_pkg
// shared widths, codes and helpers of the filter life meter
// ----------------------------------------------------------------------------
package flm_pkg;

    // operation codes of an input item
    typedef enum logic [2:0] {
        OP_USAGE_TICK  = 3'd0,
        OP_MINUTE_TICK = 3'd1,
        OP_RESET       = 3'd2,
        OP_FORCE       = 3'd3,
        OP_SET_LIFE    = 3'd4
    } op_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FLOW_ONE    = 3'd0,
        CFG_FLOW_TWO    = 3'd1,
        CFG_FLOW_THREE  = 3'd2,
        CFG_FLOW_FOUR   = 3'd3,
        CFG_WARN_FIRST  = 3'd4,
        CFG_WARN_SECOND = 3'd5,
        CFG_DAYS_FIRST  = 3'd6,
        CFG_DAYS_SECOND = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_WARN    = 2'd1,
        STATUS_REPLACE = 2'd2
    } status_t;

    localparam int FLOW_W  = 10;
    localparam int DAYS_W  = 8;
    localparam int OVR_W   = 5;
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 5;
    localparam int PROD_W  = DAYS_W + FLOW_W;      // days * top flow
    localparam int LIFE_W  = PROD_W + 11;          // times minutes per day
    localparam int NUM_W   = LIFE_W + PCT_W;       // usage * 100
    localparam int STEP_W  = 3;

    localparam logic [10:0]       MINUTES_PER_DAY = 11'd1440;
    localparam logic [15:0]       RPM_LEVEL_ONE   = 16'd400;
    localparam logic [15:0]       RPM_LEVEL_TWO   = 16'd800;
    localparam logic [15:0]       RPM_LEVEL_THREE = 16'd1200;
    localparam logic [PCT_W-1:0]  PCT_FULL        = 7'd100;
    localparam logic [CNT_W-1:0]  SAVE_PERIOD     = 5'd20;
    localparam logic [OVR_W-1:0]  DAYS_PER_WEEK   = 5'd7;
    localparam logic [2:0]        WEEKS_DEFAULT   = 3'd3;

    function automatic status_t status_of(input logic [PCT_W-1:0] pct,
                                          input logic [PCT_W-1:0] warn);
        status_t s;
        if (pct >= PCT_FULL)
            s = STATUS_REPLACE;
        else if (pct >= warn)
            s = STATUS_WARN;
        else
            s = STATUS_GOOD;
        return s;
    endfunction

endpackage

// File: hw/rtl/flm_div.sv
// ----------------------------------------------------------------------------
// flm_div
// bit-serial restoring divider giving a percent limited to full scale
// ----------------------------------------------------------------------------
module flm_div
    import flm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [LIFE_W-1:0] den,
    output logic              done,
    output logic [PCT_W-1:0]  pct
);

    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  den_sh_reg;
    logic [PCT_W-1:0]  quo_reg;

    logic [NUM_W:0]    diff;
    logic              ge;

    // the one shared compare and subtract
    assign diff = {1'b0, rem_reg} - {1'b0, den_sh_reg};
    assign ge   = ~diff[NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg <= '0;
                sat_reg <= 1'b0;
                if (den == '0)
                begin
                    // zero lifespan reads as zero percent
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rem_reg    <= num;
                    den_sh_reg <= {den, {PCT_W{1'b0}}};
                    step_reg   <= STEP_W'(PCT_W);
                    busy_reg   <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                den_sh_reg <= den_sh_reg >> 1;
                if (step_reg == STEP_W'(PCT_W))
                begin
                    // quotient of 128 or more saturates at once
                    if (ge)
                    begin
                        sat_reg  <= 1'b1;
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    step_reg <= step_reg - 1'b1;
                end
                else
                begin
                    if (ge)
                        rem_reg <= diff[NUM_W-1:0];
                    quo_reg <= {quo_reg[PCT_W-2:0], ge};
                    if (step_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                        step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign pct  = (sat_reg || quo_reg >= PCT_FULL) ? PCT_FULL : quo_reg;

endmodule

// File: hw/rtl/filter_life_meter_top.sv
// ----------------------------------------------------------------------------
// filter_life_meter_top
// wear tracking of two air filters with percent, status and save request
// ----------------------------------------------------------------------------
// usage:
//   items enter on the item channel (item_valid / item_stall) and each gives
//   one transaction on the result channel (result_valid / result_stall).
//   configuration registers are written over cfg_valid / cfg_index / cfg_data;
//   cfg_ready is always high and writes belong in idle time only.
// sequence:
//   minute tick, filter reset and undefined codes go right to the final state.
//   force replace passes the lifespan states; set lifespan adds the divide.
//   a usage tick runs the lifespan multiply and the serial percent divide
//   once per filter, skipping the divide for a filter already at its lifespan;
//   the divide runs on the one shared compare-subtract unit.
// throughput:
//   one item at a time; item_stall is high from acceptance until the result
//   has been loaded into the output register.
// reset:
//   usage and percents clear, the save countdown loads twenty and the
//   registers take their default values.
// stall:
//   a valid result holds in the result register while result_stall is high;
//   a finished item waits in its final state until the register is free.
// ----------------------------------------------------------------------------
module filter_life_meter_top
    import flm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [2:0]          operation,
    input  logic                filter_sel,
    input  logic [15:0]         rpm,
    input  logic [7:0]          weeks,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [PCT_W-1:0]    pct_first,
    output logic [1:0]          status_first,
    output logic [PCT_W-1:0]    pct_second,
    output logic [1:0]          status_second,
    output logic                save_request,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [FLOW_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIFE_MUL,
        ST_LIFE_SCALE,
        ST_APPLY,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t            state_reg;

    // configuration
    logic [FLOW_W-1:0] flow1_reg;
    logic [FLOW_W-1:0] flow2_reg;
    logic [FLOW_W-1:0] flow3_reg;
    logic [FLOW_W-1:0] flow4_reg;
    logic [PCT_W-1:0]  warn_reg [2];
    logic [DAYS_W-1:0] base_days_reg [2];

    // filter state
    logic [LIFE_W-1:0] usage_reg [2];
    logic [PCT_W-1:0]  pct_reg [2];
    logic [OVR_W-1:0]  ovr_reg [2];
    logic [CNT_W-1:0]  cnt_reg;

    // item in work
    op_t               op_reg;
    logic              fsel_reg;
    logic [FLOW_W-1:0] flow_reg;
    logic              save_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [LIFE_W-1:0] life_reg;

    // output register
    logic              res_valid_reg;
    logic [PCT_W-1:0]  res_pct_reg [2];
    status_t           res_status_reg [2];
    logic              res_save_reg;

    logic [FLOW_W-1:0] flow_next;
    logic [OVR_W-1:0]  ovr_next;
    logic [2:0]        weeks_eff;
    logic [DAYS_W-1:0] days_sel;
    logic [LIFE_W-1:0] life_full;
    logic [LIFE_W:0]   usage_sum;
    logic [NUM_W-1:0]  div_num;
    logic              div_start;
    logic              div_done;
    logic [PCT_W-1:0]  div_pct;
    logic              accept;
    logic              out_free;

    assign accept   = item_valid && (state_reg == ST_IDLE);
    assign out_free = !res_valid_reg || !result_stall;

    always_comb
    begin
        if (rpm == '0)
            flow_next = '0;
        else if (rpm <= RPM_LEVEL_ONE)
            flow_next = flow1_reg;
        else if (rpm <= RPM_LEVEL_TWO)
            flow_next = flow2_reg;
        else if (rpm <= RPM_LEVEL_THREE)
            flow_next = flow3_reg;
        else
            flow_next = flow4_reg;
    end

    always_comb
    begin
        if (weeks inside {[8'd2:8'd4]})
            weeks_eff = weeks[2:0];
        else
            weeks_eff = WEEKS_DEFAULT;
        ovr_next = OVR_W'(weeks_eff) * DAYS_PER_WEEK;
    end

    assign days_sel  = (ovr_reg[fsel_reg] != '0) ? DAYS_W'(ovr_reg[fsel_reg])
                                                  : base_days_reg[fsel_reg];
    assign life_full = LIFE_W'(prod_reg) * LIFE_W'(MINUTES_PER_DAY);
    assign usage_sum = {1'b0, usage_reg[fsel_reg]} + (LIFE_W+1)'(flow_reg);
    assign div_num   = NUM_W'(usage_reg[fsel_reg]) * NUM_W'(PCT_FULL);
    assign div_start = (state_reg == ST_DIV_START);

    flm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (life_reg),
        .done  (div_done),
        .pct   (div_pct)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow1_reg        <= 10'd2;
            flow2_reg        <= 10'd4;
            flow3_reg        <= 10'd6;
            flow4_reg        <= 10'd8;
            warn_reg[0]      <= 7'd90;
            warn_reg[1]      <= 7'd90;
            base_days_reg[0] <= 8'd21;
            base_days_reg[1] <= 8'd21;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FLOW_ONE:    flow1_reg        <= cfg_data;
                CFG_FLOW_TWO:    flow2_reg        <= cfg_data;
                CFG_FLOW_THREE:  flow3_reg        <= cfg_data;
                CFG_FLOW_FOUR:   flow4_reg        <= cfg_data;
                CFG_WARN_FIRST:  warn_reg[0]      <= cfg_data[PCT_W-1:0];
                CFG_WARN_SECOND: warn_reg[1]      <= cfg_data[PCT_W-1:0];
                CFG_DAYS_FIRST:  base_days_reg[0] <= cfg_data[DAYS_W-1:0];
                CFG_DAYS_SECOND: base_days_reg[1] <= cfg_data[DAYS_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            usage_reg[0]  <= '0;
            usage_reg[1]  <= '0;
            pct_reg[0]    <= '0;
            pct_reg[1]    <= '0;
            ovr_reg[0]    <= '0;
            ovr_reg[1]    <= '0;
            cnt_reg       <= SAVE_PERIOD;
            res_valid_reg <= 1'b0;
            save_reg      <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !result_stall)
                res_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg   <= op_t'(operation);
                        fsel_reg <= filter_sel;
                        flow_reg <= flow_next;
                        save_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                        case (op_t'(operation))
                            OP_USAGE_TICK:
                            begin
                                fsel_reg  <= 1'b0;
                                state_reg <= ST_LIFE_MUL;
                            end
                            OP_MINUTE_TICK:
                            begin
                                if (cnt_reg != '0)
                                begin
                                    if (cnt_reg == CNT_W'(1))
                                    begin
                                        save_reg <= 1'b1;
                                        cnt_reg  <= SAVE_PERIOD;
                                    end
                                    else
                                        cnt_reg <= cnt_reg - 1'b1;
                                end
                            end
                            OP_RESET:
                            begin
                                usage_reg[filter_sel] <= '0;
                                pct_reg[filter_sel]   <= '0;
                                save_reg              <= 1'b1;
                            end
                            OP_FORCE:
                                state_reg <= ST_LIFE_MUL;
                            OP_SET_LIFE:
                            begin
                                ovr_reg[filter_sel] <= ovr_next;
                                state_reg           <= ST_LIFE_MUL;
                            end
                            default:
                                state_reg <= ST_FINISH;
                        endcase
                    end
                end

                ST_LIFE_MUL:
                begin
                    prod_reg  <= PROD_W'(days_sel) * PROD_W'(flow4_reg);
                    state_reg <= ST_LIFE_SCALE;
                end

                ST_LIFE_SCALE:
                begin
                    life_reg  <= life_full;
                    state_reg <= ST_APPLY;
                end

                ST_APPLY:
                begin
                    case (op_reg)
                        OP_USAGE_TICK:
                        begin
                            if (usage_reg[fsel_reg] >= life_reg)
                            begin
                                // worn out filter keeps usage and percent
                                if (!fsel_reg)
                                begin
                                    fsel_reg  <= 1'b1;
                                    state_reg <= ST_LIFE_MUL;
                                end
                                else
                                    state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                if (usage_sum > {1'b0, life_reg})
                                    usage_reg[fsel_reg] <= life_reg;
                                else
                                    usage_reg[fsel_reg] <= usage_sum[LIFE_W-1:0];
                                state_reg <= ST_DIV_START;
                            end
                        end
                        OP_FORCE:
                        begin
                            usage_reg[fsel_reg] <= life_reg;
                            pct_reg[fsel_reg]   <= PCT_FULL;
                            save_reg            <= 1'b1;
                            state_reg           <= ST_FINISH;
                        end
                        default:
                            state_reg <= ST_DIV_START;
                    endcase
                end

                ST_DIV_START:
                    state_reg <= ST_DIV_WAIT;

                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        pct_reg[fsel_reg] <= div_pct;
                        if (op_reg == OP_USAGE_TICK && !fsel_reg)
                        begin
                            fsel_reg  <= 1'b1;
                            state_reg <= ST_LIFE_MUL;
                        end
                        else
                            state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        res_valid_reg     <= 1'b1;
                        res_pct_reg[0]    <= pct_reg[0];
                        res_pct_reg[1]    <= pct_reg[1];
                        res_status_reg[0] <= status_of(pct_reg[0], warn_reg[0]);
                        res_status_reg[1] <= status_of(pct_reg[1], warn_reg[1]);
                        res_save_reg      <= save_reg;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign item_stall    = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = res_valid_reg;
    assign pct_first     = res_pct_reg[0];
    assign status_first  = res_status_reg[0];
    assign pct_second    = res_pct_reg[1];
    assign status_second = res_status_reg[1];
    assign save_request  = res_save_reg;

    // a new result only comes out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the final state");

    // the divider only reports back while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished while not awaited");

    // stored percents never pass full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        pct_reg[0] <= PCT_FULL && pct_reg[1] <= PCT_FULL)
        else $error("stored percent above full scale");

    // save countdown stays within one period and never sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 && cnt_reg <= SAVE_PERIOD)
        else $error("save countdown out of range");

endmodule

// File: verif/flm_wear_checker.sv
// ----------------------------------------------------------------------------
// flm_wear_checker
// watches the item, result and register channels of the filter life meter,
// keeps its own copy of the wear state and checks every result transaction
// ----------------------------------------------------------------------------
module flm_wear_checker
    import flm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  logic [2:0]          operation,
    input  logic                filter_sel,
    input  logic [15:0]         rpm,
    input  logic [7:0]          weeks,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic [PCT_W-1:0]    pct_first,
    input  logic [1:0]          status_first,
    input  logic [PCT_W-1:0]    pct_second,
    input  logic [1:0]          status_second,
    input  logic                save_request,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [FLOW_W-1:0]   cfg_data,
    output int                  mismatch_count,
    output int                  readings_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] MIN_WEEKS  = 8'd2;
    localparam logic [7:0] MAX_WEEKS  = 8'd4;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [PCT_W-1:0] pct_first;
        logic [1:0]       status_first;
        logic [PCT_W-1:0] pct_second;
        logic [1:0]       status_second;
        logic             save_request;
    } reading_t;

    // register mirror
    logic [FLOW_W-1:0] flow_cfg [4];
    logic [PCT_W-1:0]  warn_cfg [2];
    logic [DAYS_W-1:0] days_cfg [2];

    // wear state
    logic [31:0]       used_units [2];
    logic [PCT_W-1:0]  used_pct [2];
    logic [OVR_W-1:0]  ovr_days [2];
    logic [CNT_W-1:0]  save_left;

    reading_t          expected_readings [$];
    int                accepted_items;
    int                checked_readings;

    assign readings_pending = accepted_items - checked_readings;

    function automatic longint unsigned filter_life(input int f);
        longint unsigned days;
        days = (ovr_days[f] != '0) ? ovr_days[f] : days_cfg[f];
        return days * MINUTES_PER_DAY * flow_cfg[CFG_FLOW_FOUR];
    endfunction

    function automatic logic [PCT_W-1:0] worn_percent(input int f);
        longint unsigned life;
        longint unsigned p;
        life = filter_life(f);
        if (life == 0)
            return '0;
        p = used_units[f];
        p = (p * PCT_FULL) / life;
        return (p > PCT_FULL) ? PCT_FULL : p[PCT_W-1:0];
    endfunction

    // a filter at or past its lifespan takes no more wear
    function automatic void add_wear(input int f, input logic [FLOW_W-1:0] flow);
        longint unsigned life;
        longint unsigned u;
        life = filter_life(f);
        u = used_units[f];
        if (u >= life)
            return;
        u = u + flow;
        if (u > life)
            u = life;
        used_units[f] = u[31:0];
        used_pct[f] = worn_percent(f);
    endfunction

    function automatic logic [1:0] wear_grade(input logic [PCT_W-1:0] pct,
                                              input logic [PCT_W-1:0] warn);
        status_t s;
        if (pct >= PCT_FULL)
            s = STATUS_REPLACE;
        else if (pct >= warn)
            s = STATUS_WARN;
        else
            s = STATUS_GOOD;
        return s;
    endfunction

    function automatic reading_t next_reading(input logic [2:0] op, input logic sel,
                                              input logic [15:0] speed,
                                              input logic [7:0] wk);
        reading_t          r;
        logic [FLOW_W-1:0] flow;
        logic [7:0]        span;
        longint unsigned   life;
        logic              save;
        save = 1'b0;
        case (op)
            OP_USAGE_TICK:
            begin
                if (speed == '0)
                    flow = '0;
                else if (speed <= RPM_LEVEL_ONE)
                    flow = flow_cfg[CFG_FLOW_ONE];
                else if (speed <= RPM_LEVEL_TWO)
                    flow = flow_cfg[CFG_FLOW_TWO];
                else if (speed <= RPM_LEVEL_THREE)
                    flow = flow_cfg[CFG_FLOW_THREE];
                else
                    flow = flow_cfg[CFG_FLOW_FOUR];
                add_wear(0, flow);
                add_wear(1, flow);
            end
            OP_MINUTE_TICK:
            begin
                if (save_left != '0)
                begin
                    save_left = save_left - 1'b1;
                    if (save_left == '0)
                    begin
                        save = 1'b1;
                        save_left = SAVE_PERIOD;
                    end
                end
            end
            OP_RESET:
            begin
                used_units[sel] = '0;
                used_pct[sel] = '0;
                save = 1'b1;
            end
            OP_FORCE:
            begin
                life = filter_life(sel);
                used_units[sel] = life[31:0];
                used_pct[sel] = PCT_FULL;
                save = 1'b1;
            end
            OP_SET_LIFE:
            begin
                span = wk;
                if (span < MIN_WEEKS || span > MAX_WEEKS)
                    span = 8'(WEEKS_DEFAULT);
                ovr_days[sel] = OVR_W'(span * DAYS_PER_WEEK);
                used_pct[sel] = worn_percent(sel);
            end
            default:
                ;
        endcase
        r.pct_first     = used_pct[0];
        r.status_first  = wear_grade(used_pct[0], warn_cfg[0]);
        r.pct_second    = used_pct[1];
        r.status_second = wear_grade(used_pct[1], warn_cfg[1]);
        r.save_request  = save;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            flow_cfg[CFG_FLOW_ONE]   = 10'd2;
            flow_cfg[CFG_FLOW_TWO]   = 10'd4;
            flow_cfg[CFG_FLOW_THREE] = 10'd6;
            flow_cfg[CFG_FLOW_FOUR]  = 10'd8;
            warn_cfg[0] = 7'd90;
            warn_cfg[1] = 7'd90;
            days_cfg[0] = 8'd21;
            days_cfg[1] = 8'd21;
            for (int f = 0; f < 2; f++)
            begin
                used_units[f] = '0;
                used_pct[f] = '0;
                ovr_days[f] = '0;
            end
            save_left = SAVE_PERIOD;
            expected_readings.delete();
            mismatch_count <= 0;
            accepted_items <= 0;
            checked_readings <= 0;
        end
        else
        begin
            // results first: a transaction accepted on this edge cannot be answered yet
            if (result_valid && !result_stall)
            begin
                got = '{pct_first, status_first, pct_second, status_second, save_request};
                if (expected_readings.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("%0t: result transaction with nothing outstanding", $time);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    checked_readings <= checked_readings + 1;
                    if (got.pct_first !== want.pct_first
                        || got.status_first !== want.status_first
                        || got.pct_second !== want.pct_second
                        || got.status_second !== want.status_second
                        || got.save_request !== want.save_request)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display({"%0t: mismatch exp pct %0d/%0d status %0d/%0d save %0d,",
                                      " got pct %0d/%0d status %0d/%0d save %0d"}, $time,
                                     want.pct_first, want.pct_second, want.status_first,
                                     want.status_second, want.save_request,
                                     got.pct_first, got.pct_second, got.status_first,
                                     got.status_second, got.save_request);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FLOW_ONE:    flow_cfg[CFG_FLOW_ONE] = cfg_data;
                    CFG_FLOW_TWO:    flow_cfg[CFG_FLOW_TWO] = cfg_data;
                    CFG_FLOW_THREE:  flow_cfg[CFG_FLOW_THREE] = cfg_data;
                    CFG_FLOW_FOUR:   flow_cfg[CFG_FLOW_FOUR] = cfg_data;
                    CFG_WARN_FIRST:  warn_cfg[0] = cfg_data[PCT_W-1:0];
                    CFG_WARN_SECOND: warn_cfg[1] = cfg_data[PCT_W-1:0];
                    CFG_DAYS_FIRST:  days_cfg[0] = cfg_data[DAYS_W-1:0];
                    CFG_DAYS_SECOND: days_cfg[1] = cfg_data[DAYS_W-1:0];
                    default:         ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                expected_readings.push_back(next_reading(operation, filter_sel, rpm, weeks));
                accepted_items <= accepted_items + 1;
            end
        end
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the filter life meter: directed ticks and commands, then
// random wear sequences over several register settings and pacing modes
// ----------------------------------------------------------------------------
module tb;
    import flm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT      = 1000000;
    localparam int         SETTLE_CYCLES    = 40;
    localparam logic [2:0] OP_FIRST_UNUSED  = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED   = 3'd7;

    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [2:0]          operation = '0;
    logic                filter_sel = 1'b0;
    logic [15:0]         rpm = '0;
    logic [7:0]          weeks = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [PCT_W-1:0]    pct_first;
    logic [1:0]          status_first;
    logic [PCT_W-1:0]    pct_second;
    logic [1:0]          status_second;
    logic                save_request;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [FLOW_W-1:0]   cfg_data = '0;
    int                  mismatch_count;
    int                  readings_pending;

    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  cycle_count = 0;

    filter_life_meter_top dut (.*);

    flm_wear_checker u_wear_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic set_pace(input pace_t mode);
        case (mode)
            PACE_FULL:           begin send_idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin send_idle_pct = 59; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 59; end
            default:             begin send_idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    task automatic apply_item(input logic [2:0] op, input logic sel,
                              input logic [15:0] speed, input logic [7:0] wk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        filter_sel <= sel;
        rpm        <= speed;
        weeks      <= wk;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // hold off new items until every result transaction has come back
    task automatic drain_meter();
        item_valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[FLOW_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_meter(input int unsigned f1, input int unsigned f2,
                                 input int unsigned f3, input int unsigned f4,
                                 input int unsigned w1, input int unsigned w2,
                                 input int unsigned d1, input int unsigned d2);
        drain_meter();
        repeat (SETTLE_CYCLES) @(posedge clk);
        put_reg(CFG_FLOW_ONE, f1);
        put_reg(CFG_FLOW_TWO, f2);
        put_reg(CFG_FLOW_THREE, f3);
        put_reg(CFG_FLOW_FOUR, f4);
        put_reg(CFG_WARN_FIRST, w1);
        put_reg(CFG_WARN_SECOND, w2);
        put_reg(CFG_DAYS_FIRST, d1);
        put_reg(CFG_DAYS_SECOND, d2);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_rpm();
        logic [15:0] lvl;
        case ($urandom_range(0, 9))
            0:
                return '0;
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       lvl = RPM_LEVEL_ONE;
                    1:       lvl = RPM_LEVEL_TWO;
                    default: lvl = RPM_LEVEL_THREE;
                endcase
                return lvl + 16'($urandom_range(0, 1));
            end
            2, 3, 4, 5, 6:
                return 16'($urandom_range(1, 1300));
            default:
                return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] pick_weeks();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 6));
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly usage ticks, with bursts that drive the filters into saturation
    task automatic run_wear_phase(input int count, input bit with_life, input int pace_base);
        int         burst_left;
        int         pick;
        logic [2:0] op;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                set_pace(pace_t'((n / 64 + pace_base) % 4));
            if ($urandom_range(0, 49) == 0)
                drain_meter();
            if (burst_left > 0)
            begin
                op = OP_USAGE_TICK;
                burst_left--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    burst_left = $urandom_range(8, 40);
                    op = OP_USAGE_TICK;
                end
                else if (pick < 50)
                    op = OP_USAGE_TICK;
                else if (pick < 70)
                    op = OP_MINUTE_TICK;
                else if (pick < 75)
                    op = OP_RESET;
                else if (pick < 80)
                    op = OP_FORCE;
                else if (pick < 96)
                    op = with_life ? OP_SET_LIFE : OP_USAGE_TICK;
                else
                    op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
            end
            apply_item(op, 1'($urandom_range(0, 1)), pick_rpm(), pick_weeks());
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_pace(PACE_FULL);

        // reset values: rpm band edges, commands and an unused code
        apply_item(OP_USAGE_TICK, 1'b0, 16'd0, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, RPM_LEVEL_ONE, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b1, RPM_LEVEL_ONE + 16'd1, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, RPM_LEVEL_TWO, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b1, RPM_LEVEL_TWO + 16'd1, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, RPM_LEVEL_THREE, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b1, RPM_LEVEL_THREE + 16'd1, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, 16'hFFFF, 8'hFF);
        apply_item(OP_MINUTE_TICK, 1'b0, 16'd0, 8'd0);
        apply_item(OP_FORCE, 1'b1, 16'd0, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, 16'hFFFF, 8'd0);
        apply_item(OP_RESET, 1'b1, 16'd0, 8'd0);
        apply_item(OP_LAST_UNUSED, 1'b1, 16'hFFFF, 8'hFF);

        // one-day first filter saturates in two ticks, warning thresholds at the limits
        program_meter(1023, 512, 0, 1, 0, 100, 1, 255);
        apply_item(OP_USAGE_TICK, 1'b0, 16'd100, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b0, 16'd100, 8'd0);
        apply_item(OP_USAGE_TICK, 1'b1, 16'd900, 8'd0);
        run_wear_phase(300, 1'b0, 0);

        // zero lifespan on both filters
        program_meter(0, 1, 2, 0, 50, 50, 7, 3);
        run_wear_phase(150, 1'b0, 1);

        program_meter(1023, 1023, 1023, 1023, 50, 100, 255, 255);
        run_wear_phase(200, 1'b0, 2);

        // lifespan in weeks, in and out of range; base days no longer count after this
        program_meter(1023, 700, 300, 1, 90, 90, 21, 21);
        apply_item(OP_SET_LIFE, 1'b0, 16'd0, 8'd2);
        apply_item(OP_SET_LIFE, 1'b1, 16'd0, 8'd4);
        apply_item(OP_SET_LIFE, 1'b0, 16'd0, 8'd0);
        apply_item(OP_SET_LIFE, 1'b1, 16'd0, 8'd255);
        apply_item(OP_SET_LIFE, 1'b0, 16'd0, 8'd5);
        apply_item(OP_SET_LIFE, 1'b1, 16'd0, 8'd1);
        run_wear_phase(300, 1'b1, 3);

        program_meter(1023, 1023, 1023, 2, 75, 40, 1, 1);
        run_wear_phase(300, 1'b1, 0);

        program_meter(5, 9, 17, 0, 100, 0, 128, 64);
        run_wear_phase(150, 1'b1, 1);

        program_meter(0, 1, 1023, 1023, 100, 0, 200, 2);
        run_wear_phase(200, 1'b1, 2);

        program_meter(511, 256, 128, 3, 60, 95, 33, 99);
        run_wear_phase(400, 1'b1, 3);

        drain_meter();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && readings_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filter_life_meter_top.f
hw/rtl/flm_pkg.sv
hw/rtl/flm_div.sv
hw/rtl/filter_life_meter_top.sv
verif/flm_wear_checker.sv
verif/tb.sv
